[rtl/mouse_packet_cursor_tracker_core_defines.svh]
// assertion macros for the mouse cursor tracker
`ifndef MOUSE_PACKET_CURSOR_TRACKER_CORE_DEFINES_SVH
`define MOUSE_PACKET_CURSOR_TRACKER_CORE_DEFINES_SVH

`ifndef SYNTHESIS
`define MPCT_ASSERT_IMP(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("same-cycle check failed");
`define MPCT_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("next-cycle check failed");
`else
`define MPCT_ASSERT_IMP(label, clk, rst, ante, cons)
`define MPCT_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif

`endif

[rtl/mpct_pkg.sv]
`timescale 1ns / 1ps

package mpct_pkg;

  localparam int DATA_BITS      = 8;
  localparam int SIZE_BITS      = 13;
  localparam int BUTTON_BITS    = 3;
  localparam int DELTA_BITS     = 9;
  localparam int CFG_INDEX_BITS = 4;

  localparam int HDR_X_SIGN = 4;
  localparam int HDR_Y_SIGN = 5;

  localparam logic [SIZE_BITS-1:0] RESET_WIDTH  = 13'd1024;
  localparam logic [SIZE_BITS-1:0] RESET_HEIGHT = 13'd768;
  localparam int unsigned CENTER_X = 512;
  localparam int unsigned CENTER_Y = 384;

  typedef enum logic [CFG_INDEX_BITS-1:0] {
    REG_SCREEN_WIDTH  = 4'd0,
    REG_SCREEN_HEIGHT = 4'd1
  } reg_index_t;

  typedef enum logic [1:0] {
    POS_HEADER = 2'd0,
    POS_X      = 2'd1,
    POS_Y      = 2'd2
  } byte_pos_t;

endpackage

[rtl/mpct_byte_if.sv]
`timescale 1ns / 1ps

interface mpct_byte_if;
  logic                           valid;
  logic                           ready;
  logic [mpct_pkg::DATA_BITS-1:0] data_byte;
  logic                           from_mouse;

  modport source (output valid, output data_byte, output from_mouse, input ready);
  modport sink   (input valid, input data_byte, input from_mouse, output ready);
endinterface

[rtl/mpct_result_if.sv]
`timescale 1ns / 1ps

interface mpct_result_if #(
  parameter int COORD_BITS = 12
);
  logic                             valid;
  logic                             ready;
  logic [COORD_BITS-1:0]            cursor_x;
  logic [COORD_BITS-1:0]            cursor_y;
  logic [mpct_pkg::BUTTON_BITS-1:0] button_bits;
  logic                             packet_done;

  modport source (output valid, output cursor_x, output cursor_y, output button_bits,
                  output packet_done, input ready);
  modport sink   (input valid, input cursor_x, input cursor_y, input button_bits,
                  input packet_done, output ready);
endinterface

[rtl/mpct_axis.sv]
`timescale 1ns / 1ps

module mpct_axis #(
  parameter int COORD_BITS = 12
) (
  input  logic [COORD_BITS-1:0]             pos,
  input  logic [mpct_pkg::DELTA_BITS-1:0]   delta,
  input  logic                              negate,
  input  logic [mpct_pkg::SIZE_BITS-1:0]    size,
  output logic [COORD_BITS-1:0]             pos_new
);

  localparam int SW = COORD_BITS + 2;
  localparam int LW = (mpct_pkg::SIZE_BITS > COORD_BITS + 1) ? mpct_pkg::SIZE_BITS
                                                             : COORD_BITS + 1;

  logic [LW-1:0]        size_w;
  logic [LW-1:0]        cap_w;
  logic [LW-1:0]        size_eff;
  logic [COORD_BITS-1:0] limit;
  logic signed [SW-1:0] pos_ext;
  logic signed [SW-1:0] delta_ext;
  logic signed [SW-1:0] sum;

  // largest legal coordinate for the configured size
  always_comb begin
    size_w = LW'(size);
    cap_w  = LW'(1) << COORD_BITS;
    if (size_w == '0) begin
      size_eff = LW'(1);
    end else if (size_w > cap_w) begin
      size_eff = cap_w;
    end else begin
      size_eff = size_w;
    end
    limit = COORD_BITS'(size_eff - LW'(1));
  end

  assign pos_ext   = signed'({2'b00, pos});
  assign delta_ext = signed'({{(SW - mpct_pkg::DELTA_BITS){delta[mpct_pkg::DELTA_BITS-1]}},
                              delta});
  assign sum       = negate ? (pos_ext - delta_ext) : (pos_ext + delta_ext);

  always_comb begin
    if (sum[SW-1]) begin
      pos_new = '0;
    end else if (sum[COORD_BITS:0] > {1'b0, limit}) begin
      pos_new = limit;
    end else begin
      pos_new = sum[COORD_BITS-1:0];
    end
  end

endmodule

[rtl/mouse_packet_cursor_tracker_core.sv]
// each byte passes the input register, then the result register; add and clamp per axis
// sit between the two; one byte per cycle unless the result side stalls
// every byte yields one result; packet_done marks the third mouse byte of a packet
// reset (rst, synchronous): packet position to header, cursor to 512/384, buttons clear,
// screen size 1024 x 768, both pipeline stages empty
`timescale 1ns / 1ps
`include "mouse_packet_cursor_tracker_core_defines.svh"

module mouse_packet_cursor_tracker_core #(
  parameter int COORD_BITS = 12
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 cfg_wr_en,
  input  logic [mpct_pkg::CFG_INDEX_BITS-1:0]  cfg_index,
  input  logic [mpct_pkg::SIZE_BITS-1:0]       cfg_data,
  mpct_byte_if.sink                            byte_in,
  mpct_result_if.source                        result_out
);

  localparam int unsigned RESET_X = mpct_pkg::CENTER_X % (1 << COORD_BITS);
  localparam int unsigned RESET_Y = mpct_pkg::CENTER_Y % (1 << COORD_BITS);

  logic [mpct_pkg::SIZE_BITS-1:0] screen_width;
  logic [mpct_pkg::SIZE_BITS-1:0] screen_height;

  logic                           s1_valid;
  logic [mpct_pkg::DATA_BITS-1:0] s1_data;
  logic                           s1_mouse;
  logic                           advance;

  mpct_pkg::byte_pos_t              byte_position;
  mpct_pkg::byte_pos_t              byte_position_next;
  logic [mpct_pkg::DATA_BITS-1:0]   header_byte;
  logic [mpct_pkg::DATA_BITS-1:0]   header_byte_next;
  logic [mpct_pkg::DATA_BITS-1:0]   x_delta_byte;
  logic [mpct_pkg::DATA_BITS-1:0]   x_delta_byte_next;
  logic [COORD_BITS-1:0]            pos_x;
  logic [COORD_BITS-1:0]            pos_x_next;
  logic [COORD_BITS-1:0]            pos_y;
  logic [COORD_BITS-1:0]            pos_y_next;
  logic [mpct_pkg::BUTTON_BITS-1:0] buttons_held;
  logic [mpct_pkg::BUTTON_BITS-1:0] buttons_held_next;
  logic                             done_next;

  logic [COORD_BITS-1:0]            x_clamped;
  logic [COORD_BITS-1:0]            y_clamped;

  logic                             out_valid;
  logic [COORD_BITS-1:0]            out_x;
  logic [COORD_BITS-1:0]            out_y;
  logic [mpct_pkg::BUTTON_BITS-1:0] out_buttons;
  logic                             out_done;

  // configuration
  always_ff @(posedge clk) begin
    if (rst) begin
      screen_width  <= mpct_pkg::RESET_WIDTH;
      screen_height <= mpct_pkg::RESET_HEIGHT;
    end else if (cfg_wr_en) begin
      if (cfg_index == mpct_pkg::REG_SCREEN_WIDTH) begin
        screen_width <= cfg_data;
      end
      if (cfg_index == mpct_pkg::REG_SCREEN_HEIGHT) begin
        screen_height <= cfg_data;
      end
    end
  end

  // input register
  assign advance       = s1_valid && (!out_valid || result_out.ready);
  assign byte_in.ready = !s1_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (byte_in.ready) begin
      s1_valid <= byte_in.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (byte_in.valid && byte_in.ready) begin
      s1_data  <= byte_in.data_byte;
      s1_mouse <= byte_in.from_mouse;
    end
  end

  // per-axis add and clamp
  mpct_axis #(.COORD_BITS(COORD_BITS)) u_axis_x (
    .pos     (pos_x),
    .delta   ({header_byte[mpct_pkg::HDR_X_SIGN], x_delta_byte}),
    .negate  (1'b0),
    .size    (screen_width),
    .pos_new (x_clamped)
  );

  mpct_axis #(.COORD_BITS(COORD_BITS)) u_axis_y (
    .pos     (pos_y),
    .delta   ({header_byte[mpct_pkg::HDR_Y_SIGN], s1_data}),
    .negate  (1'b1),
    .size    (screen_height),
    .pos_new (y_clamped)
  );

  // packet assembly
  always_comb begin
    byte_position_next = byte_position;
    header_byte_next   = header_byte;
    x_delta_byte_next  = x_delta_byte;
    pos_x_next         = pos_x;
    pos_y_next         = pos_y;
    buttons_held_next  = buttons_held;
    done_next          = 1'b0;
    if (s1_mouse) begin
      unique case (byte_position)
        mpct_pkg::POS_HEADER: begin
          header_byte_next   = s1_data;
          byte_position_next = mpct_pkg::POS_X;
        end
        mpct_pkg::POS_X: begin
          x_delta_byte_next  = s1_data;
          byte_position_next = mpct_pkg::POS_Y;
        end
        default: begin
          byte_position_next = mpct_pkg::POS_HEADER;
          buttons_held_next  = header_byte[mpct_pkg::BUTTON_BITS-1:0];
          pos_x_next         = x_clamped;
          pos_y_next         = y_clamped;
          done_next          = 1'b1;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_position <= mpct_pkg::POS_HEADER;
      header_byte   <= '0;
      x_delta_byte  <= '0;
      pos_x         <= COORD_BITS'(RESET_X);
      pos_y         <= COORD_BITS'(RESET_Y);
      buttons_held  <= '0;
    end else if (advance) begin
      byte_position <= byte_position_next;
      header_byte   <= header_byte_next;
      x_delta_byte  <= x_delta_byte_next;
      pos_x         <= pos_x_next;
      pos_y         <= pos_y_next;
      buttons_held  <= buttons_held_next;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (result_out.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_x       <= pos_x_next;
      out_y       <= pos_y_next;
      out_buttons <= buttons_held_next;
      out_done    <= done_next;
    end
  end

  assign result_out.valid       = out_valid;
  assign result_out.cursor_x    = out_x;
  assign result_out.cursor_y    = out_y;
  assign result_out.button_bits = out_buttons;
  assign result_out.packet_done = out_done;

  `MPCT_ASSERT_IMP(a_result_tracks_xy, clk, rst, out_valid, (out_x == pos_x) && (out_y == pos_y))
  `MPCT_ASSERT_IMP(a_result_tracks_buttons, clk, rst, out_valid, out_buttons == buttons_held)
  `MPCT_ASSERT_IMP(a_done_to_header, clk, rst, out_valid && out_done, byte_position == mpct_pkg::POS_HEADER)
  `MPCT_ASSERT_IMP(a_position_legal, clk, rst, 1'b1, byte_position != 2'd3)
  `MPCT_ASSERT_NEXT(a_stage_holds, clk, rst, s1_valid && !advance, s1_valid)

endmodule

[tb/mouse_packet_cursor_tracker_core_test.sv]
`timescale 1ns / 1ps

module mouse_packet_cursor_tracker_core_test;

  localparam int COORD_BITS = 12;
  localparam int DATA_BITS = mpct_pkg::DATA_BITS;
  localparam int SIZE_BITS = mpct_pkg::SIZE_BITS;
  localparam int BUTTON_BITS = mpct_pkg::BUTTON_BITS;
  localparam int CFG_INDEX_BITS = mpct_pkg::CFG_INDEX_BITS;
  localparam int MOUSE_BYTES = 1360;
  localparam int PHASES = 8;
  localparam int MAX_GAP = 4;
  localparam int LONG_HOLD_CYCLES = 120;
  localparam int SETTLE_CYCLES = 6;
  localparam int RESET_CYCLES = 10;
  localparam logic [SIZE_BITS-1:0] SIZE_MAX = '1;
  localparam logic [SIZE_BITS-1:0] SIZE_CAP = SIZE_BITS'(1 << COORD_BITS);

  typedef struct packed {
    logic [COORD_BITS-1:0]  cursor_x;
    logic [COORD_BITS-1:0]  cursor_y;
    logic [BUTTON_BITS-1:0] button_bits;
    logic                   packet_done;
  } cursor_report_t;

  class cursor_predictor;
    logic [SIZE_BITS-1:0]   width_reg;
    logic [SIZE_BITS-1:0]   height_reg;
    mpct_pkg::byte_pos_t    pos;
    logic [DATA_BITS-1:0]   header;
    logic [DATA_BITS-1:0]   x_byte;
    logic [COORD_BITS-1:0]  x;
    logic [COORD_BITS-1:0]  y;
    logic [BUTTON_BITS-1:0] buttons;
    cursor_report_t         pending[$];
    int                     mismatches;
    int                     packets;

    function void reset();
      width_reg = mpct_pkg::RESET_WIDTH;
      height_reg = mpct_pkg::RESET_HEIGHT;
      pos = mpct_pkg::POS_HEADER;
      header = '0;
      x_byte = '0;
      x = COORD_BITS'(mpct_pkg::CENTER_X);
      y = COORD_BITS'(mpct_pkg::CENTER_Y);
      buttons = '0;
      pending.delete();
      mismatches = 0;
      packets = 0;
    endfunction

    function void write_reg(logic [CFG_INDEX_BITS-1:0] idx, logic [SIZE_BITS-1:0] val);
      case (idx)
        mpct_pkg::REG_SCREEN_WIDTH:  width_reg = val;
        mpct_pkg::REG_SCREEN_HEIGHT: height_reg = val;
        default: ;
      endcase
    endfunction

    // zero counts as one, anything past the coordinate range is capped
    static function int axis_limit(logic [SIZE_BITS-1:0] size);
      int s;
      s = int'(size);
      if (s == 0) s = 1;
      if (s > (1 << COORD_BITS)) s = 1 << COORD_BITS;
      return s - 1;
    endfunction

    static function logic [COORD_BITS-1:0] clamp_axis(int v, int lim);
      if (v < 0) return '0;
      if (v > lim) return COORD_BITS'(lim);
      return COORD_BITS'(v);
    endfunction

    static function int signed_delta(logic [DATA_BITS-1:0] b, logic neg);
      int d;
      d = int'(b);
      if (neg) d -= (1 << DATA_BITS);
      return d;
    endfunction

    function void note_byte(logic [DATA_BITS-1:0] d, logic mouse);
      cursor_report_t r;
      logic done;
      int dx;
      int dy;
      done = 1'b0;
      if (mouse) begin
        case (pos)
          mpct_pkg::POS_HEADER: begin
            header = d;
            pos = mpct_pkg::POS_X;
          end
          mpct_pkg::POS_X: begin
            x_byte = d;
            pos = mpct_pkg::POS_Y;
          end
          default: begin
            dx = signed_delta(x_byte, header[mpct_pkg::HDR_X_SIGN]);
            dy = signed_delta(d, header[mpct_pkg::HDR_Y_SIGN]);
            pos = mpct_pkg::POS_HEADER;
            buttons = header[BUTTON_BITS-1:0];
            x = clamp_axis(int'(x) + dx, axis_limit(width_reg));
            y = clamp_axis(int'(y) - dy, axis_limit(height_reg));
            done = 1'b1;
          end
        endcase
      end
      r.cursor_x = x;
      r.cursor_y = y;
      r.button_bits = buttons;
      r.packet_done = done;
      pending.push_back(r);
    endfunction

    function void check_report(cursor_report_t got);
      cursor_report_t want;
      if (pending.size() == 0) begin
        $error("result with no byte outstanding: x %0d y %0d", got.cursor_x, got.cursor_y);
        mismatches++;
        return;
      end
      want = pending.pop_front();
      if (got.cursor_x !== want.cursor_x) begin
        $error("cursor_x: expected %0d, actual %0d", want.cursor_x, got.cursor_x);
        mismatches++;
      end
      if (got.cursor_y !== want.cursor_y) begin
        $error("cursor_y: expected %0d, actual %0d", want.cursor_y, got.cursor_y);
        mismatches++;
      end
      if (got.button_bits !== want.button_bits) begin
        $error("button_bits: expected %0d, actual %0d", want.button_bits, got.button_bits);
        mismatches++;
      end
      if (got.packet_done !== want.packet_done) begin
        $error("packet_done: expected %0d, actual %0d", want.packet_done, got.packet_done);
        mismatches++;
      end
      if (want.packet_done) packets++;
    endfunction
  endclass

  logic                      clk = 1'b0;
  logic                      rst;
  logic                      cfg_wr_en;
  logic [CFG_INDEX_BITS-1:0] cfg_index;
  logic [SIZE_BITS-1:0]      cfg_data;

  mpct_byte_if byte_bus();
  mpct_result_if #(.COORD_BITS(COORD_BITS)) report_bus();

  mouse_packet_cursor_tracker_core #(.COORD_BITS(COORD_BITS)) u_dut (
    .clk        (clk),
    .rst        (rst),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .byte_in    (byte_bus),
    .result_out (report_bus)
  );

  cursor_predictor tracker = new();

  bit src_burst;
  bit snk_burst;
  bit long_hold_req;
  int mouse_sent;
  int ignored_sent;
  int settings_used;

  always #10 clk = ~clk;

  task automatic send_byte(input logic [DATA_BITS-1:0] d, input logic mouse);
    int gap;
    if ($urandom_range(0, 31) == 0) src_burst = ~src_burst;
    gap = src_burst ? 0 : $urandom_range(0, MAX_GAP);
    if (gap > 0) begin
      byte_bus.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    byte_bus.valid <= 1'b1;
    byte_bus.data_byte <= d;
    byte_bus.from_mouse <= mouse;
    @(posedge clk);
    while (!byte_bus.ready) @(posedge clk);
    tracker.note_byte(d, mouse);
    if (mouse) mouse_sent++;
    else ignored_sent++;
  endtask

  task automatic send_packet(input logic [DATA_BITS-1:0] h, input logic [DATA_BITS-1:0] xb,
                             input logic [DATA_BITS-1:0] yb, input bit noisy);
    logic [DATA_BITS-1:0] bytes [3];
    bytes[0] = h;
    bytes[1] = xb;
    bytes[2] = yb;
    for (int i = 0; i < 3; i++) begin
      if (noisy && $urandom_range(0, 9) == 0) send_byte(DATA_BITS'($urandom_range(0, 255)), 1'b0);
      send_byte(bytes[i], 1'b1);
    end
  endtask

  task automatic drain();
    byte_bus.valid <= 1'b0;
    while (tracker.pending.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_INDEX_BITS-1:0] idx,
                           input logic [SIZE_BITS-1:0] val);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    tracker.write_reg(idx, val);
    cfg_wr_en <= 1'b0;
    @(posedge clk);
  endtask

  task automatic set_screen(input logic [SIZE_BITS-1:0] w, input logic [SIZE_BITS-1:0] h);
    logic [CFG_INDEX_BITS-1:0] bad_idx;
    bad_idx = CFG_INDEX_BITS'($urandom_range(int'(mpct_pkg::REG_SCREEN_HEIGHT) + 1,
                                             (1 << CFG_INDEX_BITS) - 1));
    write_reg(mpct_pkg::REG_SCREEN_WIDTH, w);
    write_reg(mpct_pkg::REG_SCREEN_HEIGHT, h);
    // write to an unused index must leave both sizes alone
    write_reg(bad_idx, SIZE_BITS'($urandom_range(0, int'(SIZE_MAX))));
    settings_used++;
  endtask

  task automatic random_phase(input int target, input bit pause_midway);
    int sent;
    int kind;
    bit paused;
    sent = 0;
    paused = 1'b0;
    while (sent < target) begin
      kind = $urandom_range(0, 19);
      if (kind == 0) begin
        send_byte(DATA_BITS'($urandom_range(0, 255)), 1'b0);
      end else if (kind == 1) begin
        // stray mouse byte shifts the packet framing
        send_byte(DATA_BITS'($urandom_range(0, 255)), 1'b1);
        sent++;
      end else begin
        send_packet(DATA_BITS'($urandom_range(0, 255)), DATA_BITS'($urandom_range(0, 255)),
                    DATA_BITS'($urandom_range(0, 255)), 1'b1);
        sent += 3;
      end
      if (pause_midway && !paused && sent >= target / 2) begin
        drain();
        paused = 1'b1;
      end
    end
  endtask

  // result side
  initial begin
    cursor_report_t got;
    int gap;
    report_bus.ready <= 1'b0;
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      if (long_hold_req) begin
        report_bus.ready <= 1'b0;
        repeat (LONG_HOLD_CYCLES) @(posedge clk);
        long_hold_req = 1'b0;
      end
      if ($urandom_range(0, 31) == 0) snk_burst = ~snk_burst;
      gap = snk_burst ? 0 : $urandom_range(0, MAX_GAP);
      if (gap > 0) begin
        report_bus.ready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      report_bus.ready <= 1'b1;
      @(posedge clk);
      while (!report_bus.valid) @(posedge clk);
      got.cursor_x = report_bus.cursor_x;
      got.cursor_y = report_bus.cursor_y;
      got.button_bits = report_bus.button_bits;
      got.packet_done = report_bus.packet_done;
      tracker.check_report(got);
    end
  end

  initial begin
    logic [SIZE_BITS-1:0] w;
    logic [SIZE_BITS-1:0] h;
    rst <= 1'b1;
    cfg_wr_en <= 1'b0;
    cfg_index <= '0;
    cfg_data <= '0;
    byte_bus.valid <= 1'b0;
    byte_bus.data_byte <= '0;
    byte_bus.from_mouse <= 1'b0;
    tracker.reset();
    repeat (RESET_CYCLES) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed part at the reset screen size
    send_byte(8'hFF, 1'b0);
    send_packet(8'h07, 8'hFF, 8'h00, 1'b0);
    send_packet(8'h10, 8'h00, 8'h00, 1'b0);
    send_packet(8'h20, 8'h00, 8'h00, 1'b0);
    send_packet(8'hC8, 8'h7F, 8'h7F, 1'b0);
    // ignored bytes in the middle of a packet
    send_byte(8'h3F, 1'b1);
    send_byte(8'h55, 1'b0);
    send_byte(8'h01, 1'b1);
    send_byte(8'hAA, 1'b0);
    send_byte(8'hFF, 1'b1);
    send_packet(8'h00, 8'hFF, 8'hFF, 1'b0);
    drain();

    // zero height pins y, a new size does not move the cursor by itself
    set_screen(13'd1, 13'd0);
    send_byte(8'h00, 1'b0);
    send_packet(8'h05, 8'h40, 8'h40, 1'b0);
    drain();
    set_screen(SIZE_MAX, SIZE_MAX);
    send_byte(8'h00, 1'b0);
    send_packet(8'h02, 8'hFF, 8'h80, 1'b0);
    drain();

    for (int p = 0; p < PHASES; p++) begin
      case (p)
        0: begin
          w = 13'd0;
          h = SIZE_MAX;
        end
        1: begin
          w = 13'd1;
          h = 13'd1;
        end
        2: begin
          w = SIZE_CAP;
          h = SIZE_CAP;
        end
        3: begin
          w = SIZE_BITS'($urandom_range(1, 64));
          h = SIZE_BITS'($urandom_range(1, 64));
        end
        5: begin
          w = SIZE_MAX;
          h = SIZE_CAP + 1'b1;
        end
        default: begin
          w = SIZE_BITS'($urandom_range(0, int'(SIZE_MAX)));
          h = SIZE_BITS'($urandom_range(0, int'(SIZE_MAX)));
        end
      endcase
      set_screen(w, h);
      if (p == 2) long_hold_req = 1'b1;
      random_phase(MOUSE_BYTES / PHASES, p == 4);
      drain();
    end

    $display("sent %0d mouse bytes and %0d ignored bytes, %0d packets completed",
             mouse_sent, ignored_sent, tracker.packets);
    $display("screen size settings used: %0d, zero and oversized sizes included",
             settings_used);
    if (tracker.mismatches == 0 && tracker.pending.size() == 0) begin
      $display("mouse_packet_cursor_tracker_core_test OK");
    end else begin
      $display("mouse_packet_cursor_tracker_core_test NOT OK");
    end
    $finish;
  end

  initial begin
    #(4_000_000);
    $display("timeout with %0d results outstanding", tracker.pending.size());
    $display("mouse_packet_cursor_tracker_core_test NOT OK");
    $finish;
  end

endmodule

[files.f]
+incdir+rtl
rtl/mpct_pkg.sv
rtl/mpct_byte_if.sv
rtl/mpct_result_if.sv
rtl/mpct_axis.sv
rtl/mouse_packet_cursor_tracker_core.sv
tb/mouse_packet_cursor_tracker_core_test.sv
